>>> sv/bef_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the buddy external fragmentation score unit.
// No dependencies; every other file uses it by scoped names.
package bef_pkg;

    localparam int ORDER_TOP_DEFAULT = 10;
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int COUNT_W = 32;
    localparam int ORDER_W = 4;
    localparam int PAGES_W = 32;
    localparam int SUM_W = 48;
    localparam int PCT_W = 7;
    localparam int NODE_W = 10;
    localparam int REM_W = 55;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS = 7;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [NODE_W-1:0] NODE_MAX = '1;
    localparam logic [PCT_W-1:0] PCT_SCALE = 7'd100;
    localparam logic [ORDER_W-1:0] HPAGE_RESET = 4'd9;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_HPAGE_ORDER = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NODE_PAGES = 1'b1;

    // one closed zone handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0]   free_sum;
        logic [SUM_W-1:0]   suit_sum;
        logic [PAGES_W-1:0] zone_pages;
        logic               last_zone;
    } t_job;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIFF  = 8'b0000_0010,
        S_SCALE = 8'b0000_0100,
        S_PDIV  = 8'b0000_1000,
        S_WMUL  = 8'b0001_0000,
        S_WCHK  = 8'b0010_0000,
        S_WDIV  = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_back_state;

endpackage

>>> sv/bef_front.sv
`timescale 1ns / 1ps
// Front end: accepts order words, accumulates free and suitable page sums,
// and pushes one job per closed zone into the queue. Uses bef_pkg.
module bef_front #(
    parameter int TOP_ORDER = bef_pkg::ORDER_TOP_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bef_pkg::COUNT_W-1:0]   i_block_count,
    input  logic [bef_pkg::ORDER_W-1:0]   i_block_order,
    input  logic [bef_pkg::PAGES_W-1:0]   i_zone_pages,
    input  logic                          i_last_order,
    input  logic                          i_last_zone,
    input  logic [bef_pkg::ORDER_W-1:0]   i_hpage_order,
    input  logic                          i_full,
    output logic                          o_push,
    output bef_pkg::t_job                 o_job
);

    localparam int ADD_W = bef_pkg::COUNT_W + 15;

    logic [bef_pkg::SUM_W-1:0] r_free_sum, n_free_sum;
    logic [bef_pkg::SUM_W-1:0] r_suit_sum, n_suit_sum;
    logic                      w_accept;
    logic                      w_in_range;
    logic                      w_suitable;
    logic [ADD_W-1:0]          w_free_add;
    logic [ADD_W-1:0]          w_suit_add;
    logic [bef_pkg::SUM_W:0]   w_free_tot;
    logic [bef_pkg::SUM_W:0]   w_suit_tot;
    logic [bef_pkg::SUM_W-1:0] w_free_next;
    logic [bef_pkg::SUM_W-1:0] w_suit_next;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;

    assign w_in_range = (i_block_order <= bef_pkg::ORDER_W'(TOP_ORDER));
    assign w_suitable = w_in_range && (i_block_order >= i_hpage_order);
    assign w_free_add = ADD_W'(i_block_count) << i_block_order;
    assign w_suit_add = ADD_W'(i_block_count) << (i_block_order - i_hpage_order);

    assign w_free_tot = {1'b0, r_free_sum} + (bef_pkg::SUM_W + 1)'(w_free_add);
    assign w_suit_tot = {1'b0, r_suit_sum} + (bef_pkg::SUM_W + 1)'(w_suit_add);

    always_comb begin
        w_free_next = r_free_sum;
        w_suit_next = r_suit_sum;
        if (w_in_range) begin
            w_free_next = w_free_tot[bef_pkg::SUM_W] ? bef_pkg::SUM_MAX
                                                     : w_free_tot[bef_pkg::SUM_W-1:0];
        end
        if (w_suitable) begin
            w_suit_next = w_suit_tot[bef_pkg::SUM_W] ? bef_pkg::SUM_MAX
                                                     : w_suit_tot[bef_pkg::SUM_W-1:0];
        end
    end

    assign o_push           = w_accept && i_last_order;
    assign o_job.free_sum   = w_free_next;
    assign o_job.suit_sum   = w_suit_next;
    assign o_job.zone_pages = i_zone_pages;
    assign o_job.last_zone  = i_last_zone;

    always_comb begin
        n_free_sum = r_free_sum;
        n_suit_sum = r_suit_sum;
        if (w_accept) begin
            // clear the sums once the zone is handed off
            n_free_sum = i_last_order ? '0 : w_free_next;
            n_suit_sum = i_last_order ? '0 : w_suit_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_sum <= '0;
            r_suit_sum <= '0;
        end else begin
            r_free_sum <= n_free_sum;
            r_suit_sum <= n_suit_sum;
        end
    end

endmodule

>>> sv/bef_queue.sv
`timescale 1ns / 1ps
// Short job queue between front and back, so each side stalls on its own.
// Uses bef_pkg for the job type.
module bef_queue #(
    parameter int DEPTH = bef_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bef_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    input  logic          i_pop,
    output bef_pkg::t_job o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    bef_pkg::t_job    r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == (AW + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

>>> sv/bef_back.sv
`timescale 1ns / 1ps
// Back end: per closed zone computes percentage, weight and node sum with a
// shared 7-step restoring divider, then holds the result word. Uses bef_pkg.
module bef_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_job_valid,
    input  bef_pkg::t_job                   i_job,
    output logic                            o_pop,
    input  logic [bef_pkg::ORDER_W-1:0]     i_hpage_order,
    input  logic [bef_pkg::CFG_DATA_W-1:0]  i_node_pages,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bef_pkg::PCT_W-1:0]       o_zone_percent,
    output logic [bef_pkg::PCT_W-1:0]       o_zone_weighted,
    output logic [bef_pkg::NODE_W-1:0]      o_node_score,
    output logic                            o_node_done
);

    localparam int WIDE_W = bef_pkg::SUM_W + 15;
    localparam int PROD_W = bef_pkg::PAGES_W + bef_pkg::PCT_W;
    localparam int DEN_W  = bef_pkg::CFG_DATA_W + 1;
    localparam int CNT_W  = $clog2(bef_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(bef_pkg::DIV_STEPS - 1);

    bef_pkg::t_back_state r_state, n_state;

    logic [bef_pkg::SUM_W-1:0]   r_free, n_free;
    logic [bef_pkg::SUM_W-1:0]   r_suit, n_suit;
    logic [bef_pkg::PAGES_W-1:0] r_zpages, n_zpages;
    logic                        r_last_zone, n_last_zone;
    logic [bef_pkg::REM_W-1:0]   r_rem, n_rem;
    logic [bef_pkg::REM_W-1:0]   r_dsr, n_dsr;
    logic [bef_pkg::PCT_W-1:0]   r_quo, n_quo;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic [bef_pkg::PCT_W-1:0]   r_pct, n_pct;
    logic                        r_wsat, n_wsat;
    logic [bef_pkg::NODE_W-1:0]  r_node_sum, n_node_sum;
    logic                        r_out_valid, n_out_valid;
    logic [bef_pkg::PCT_W-1:0]   r_out_pct, n_out_pct;
    logic [bef_pkg::PCT_W-1:0]   r_out_wgt, n_out_wgt;
    logic [bef_pkg::NODE_W-1:0]  r_out_node, n_out_node;
    logic                        r_out_done, n_out_done;

    logic [WIDE_W-1:0]           w_suit_pages;
    logic [WIDE_W-1:0]           w_free_wide;
    logic [bef_pkg::SUM_W-1:0]   w_diff;
    logic                        w_ge;
    logic [bef_pkg::REM_W-1:0]   w_rem_sub;
    logic [bef_pkg::PCT_W-1:0]   w_pct;
    logic [PROD_W-1:0]           w_prod;
    logic [DEN_W-1:0]            w_den;
    logic                        w_ovf;
    logic [bef_pkg::PCT_W-1:0]   w_weighted;
    logic [bef_pkg::NODE_W:0]    w_node_add;
    logic [bef_pkg::NODE_W-1:0]  w_node_next;
    logic                        w_out_free;

    assign w_out_free   = !r_out_valid || i_ready;

    assign w_suit_pages = WIDE_W'(r_suit) << i_hpage_order;
    assign w_free_wide  = WIDE_W'(r_free);
    assign w_diff       = (w_suit_pages > w_free_wide) ? '0
                        : bef_pkg::SUM_W'(w_free_wide - w_suit_pages);

    // shared restoring divider step
    assign w_ge      = (r_rem >= r_dsr);
    assign w_rem_sub = r_rem - r_dsr;

    assign w_pct  = (r_free == '0) ? '0 : r_quo;
    assign w_prod = PROD_W'(r_zpages) * PROD_W'(w_pct);
    assign w_den  = DEN_W'(i_node_pages) + DEN_W'(1);
    assign w_ovf  = ({1'b0, r_rem[PROD_W-1:0]} >= {w_den, 7'b0});

    assign w_weighted  = (r_wsat || (r_quo > bef_pkg::PCT_SCALE)) ? bef_pkg::PCT_SCALE : r_quo;
    assign w_node_add  = {1'b0, r_node_sum} + (bef_pkg::NODE_W + 1)'(w_weighted);
    assign w_node_next = w_node_add[bef_pkg::NODE_W] ? bef_pkg::NODE_MAX
                                                     : w_node_add[bef_pkg::NODE_W-1:0];

    assign o_pop = (r_state == bef_pkg::S_IDLE) && i_job_valid;

    always_comb begin
        n_state     = r_state;
        n_free      = r_free;
        n_suit      = r_suit;
        n_zpages    = r_zpages;
        n_last_zone = r_last_zone;
        n_rem       = r_rem;
        n_dsr       = r_dsr;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_pct       = r_pct;
        n_wsat      = r_wsat;
        n_node_sum  = r_node_sum;
        n_out_valid = r_out_valid && !i_ready;
        n_out_pct   = r_out_pct;
        n_out_wgt   = r_out_wgt;
        n_out_node  = r_out_node;
        n_out_done  = r_out_done;
        unique case (r_state)
            bef_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    n_free      = i_job.free_sum;
                    n_suit      = i_job.suit_sum;
                    n_zpages    = i_job.zone_pages;
                    n_last_zone = i_job.last_zone;
                    n_state     = bef_pkg::S_DIFF;
                end
            end
            bef_pkg::S_DIFF: begin
                n_rem   = bef_pkg::REM_W'(w_diff);
                n_state = bef_pkg::S_SCALE;
            end
            bef_pkg::S_SCALE: begin
                // times 100 as 64 + 32 + 4
                n_rem   = (r_rem << 6) + (r_rem << 5) + (r_rem << 2);
                n_dsr   = bef_pkg::REM_W'({r_free, 6'b0});
                n_quo   = '0;
                n_cnt   = '0;
                n_state = bef_pkg::S_PDIV;
            end
            bef_pkg::S_PDIV: begin
                if (w_ge) begin
                    n_rem = w_rem_sub;
                end
                n_quo = {r_quo[bef_pkg::PCT_W-2:0], w_ge};
                n_dsr = r_dsr >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = bef_pkg::S_WMUL;
                end
            end
            bef_pkg::S_WMUL: begin
                n_pct   = w_pct;
                n_rem   = bef_pkg::REM_W'(w_prod);
                n_state = bef_pkg::S_WCHK;
            end
            bef_pkg::S_WCHK: begin
                // a quotient of 128 or more saturates anyway
                n_wsat  = w_ovf;
                n_dsr   = bef_pkg::REM_W'({w_den, 6'b0});
                n_quo   = '0;
                n_cnt   = '0;
                n_state = bef_pkg::S_WDIV;
            end
            bef_pkg::S_WDIV: begin
                if (w_ge) begin
                    n_rem = w_rem_sub;
                end
                n_quo = {r_quo[bef_pkg::PCT_W-2:0], w_ge};
                n_dsr = r_dsr >> 1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = bef_pkg::S_EMIT;
                end
            end
            bef_pkg::S_EMIT: begin
                // hold until the output word is free
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_pct   = r_pct;
                    n_out_wgt   = w_weighted;
                    n_out_node  = w_node_next;
                    n_out_done  = r_last_zone;
                    n_node_sum  = r_last_zone ? '0 : w_node_next;
                    n_state     = bef_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bef_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bef_pkg::S_IDLE;
            r_node_sum  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_node_sum  <= n_node_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free      <= n_free;
        r_suit      <= n_suit;
        r_zpages    <= n_zpages;
        r_last_zone <= n_last_zone;
        r_rem       <= n_rem;
        r_dsr       <= n_dsr;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_pct       <= n_pct;
        r_wsat      <= n_wsat;
        r_out_pct   <= n_out_pct;
        r_out_wgt   <= n_out_wgt;
        r_out_node  <= n_out_node;
        r_out_done  <= n_out_done;
    end

    assign o_valid         = r_out_valid;
    assign o_zone_percent  = r_out_pct;
    assign o_zone_weighted = r_out_wgt;
    assign o_node_score    = r_out_node;
    assign o_node_done     = r_out_done;

    a_pct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bef_pkg::S_WMUL && r_free != '0) |-> (r_quo <= bef_pkg::PCT_SCALE))
        else $error("percentage divider produced a quotient above 100");

    a_out_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == bef_pkg::S_EMIT))
        else $error("result word loaded outside the emit step");

    a_emit_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bef_pkg::S_EMIT && r_out_valid && !i_ready) |=>
        (r_state == bef_pkg::S_EMIT))
        else $error("emit left while the result word was still pending");

endmodule

>>> sv/buddy_external_fragmentation_score_unit.sv
`timescale 1ns / 1ps
// Buddy external fragmentation score: order words in; a word per closed zone out.
// Order words are taken one per cycle while the job queue has room; the back end takes
// each closed zone through two 7-step passes of its shared restoring divider, and pops
// a new job from the queue only from its idle state.
// Reset (synchronous, active low) clears sums, node sum, queue and output valid;
// hpage_order returns to 9 and node_pages to 0. Uses bef_pkg, bef_front, bef_queue, bef_back.
module buddy_external_fragmentation_score_unit #(
    parameter int TOP_ORDER   = bef_pkg::ORDER_TOP_DEFAULT,
    parameter int QUEUE_DEPTH = bef_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bef_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [bef_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // block_count [31:0], block_order [35:32], zone_pages [67:36], zero [71:68]
    input  logic [71:0]                       s_axis_tdata,
    input  logic                              s_axis_tlast,   // last_order
    input  logic                              s_axis_tuser,   // last_zone
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // zone_percent [6:0], zone_weighted [13:7], node_score [23:14]
    output logic [23:0]                       m_axis_tdata,
    output logic                              m_axis_tlast    // node_done
);

    logic [bef_pkg::ORDER_W-1:0]    r_hpage_order;
    logic [bef_pkg::CFG_DATA_W-1:0] r_node_pages;

    logic          w_push;
    logic          w_full;
    logic          w_job_valid;
    logic          w_pop;
    bef_pkg::t_job w_push_job;
    bef_pkg::t_job w_pop_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hpage_order <= bef_pkg::HPAGE_RESET;
            r_node_pages  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                bef_pkg::CFG_HPAGE_ORDER: r_hpage_order <= i_cfg_wdata[bef_pkg::ORDER_W-1:0];
                bef_pkg::CFG_NODE_PAGES:  r_node_pages  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    bef_front #(
        .TOP_ORDER (TOP_ORDER)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_block_count (s_axis_tdata[31:0]),
        .i_block_order (s_axis_tdata[35:32]),
        .i_zone_pages  (s_axis_tdata[67:36]),
        .i_last_order  (s_axis_tlast),
        .i_last_zone   (s_axis_tuser),
        .i_hpage_order (r_hpage_order),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    bef_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .i_pop   (w_pop),
        .o_job   (w_pop_job)
    );

    bef_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (w_job_valid),
        .i_job           (w_pop_job),
        .o_pop           (w_pop),
        .i_hpage_order   (r_hpage_order),
        .i_node_pages    (r_node_pages),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_zone_percent  (m_axis_tdata[6:0]),
        .o_zone_weighted (m_axis_tdata[13:7]),
        .o_node_score    (m_axis_tdata[23:14]),
        .o_node_done     (m_axis_tlast)
    );

endmodule
